// ----- hdl/quaternion_vector_rotate_macros.svh -----
// Assertion macros for the quaternion vector rotation block.
`ifndef QUATERNION_VECTOR_ROTATE_MACROS_SVH
`define QUATERNION_VECTOR_ROTATE_MACROS_SVH

// Same-cycle implication, clocked on clk_i, off during reset.
`define QVR_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Implication with a fixed delay in cycles.
`define QVR_ASSERT_LAT(lbl, ante, n, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> ##n (cons)) \
    else $error(msg);

`endif

// ----- hdl/qvr_pkg.sv -----
// Shared widths and constants for the quaternion vector rotation block.
`default_nettype none

package qvr_pkg;

  localparam int QUAT_W = 18;
  localparam int VEC_W  = 32;
  localparam int OUT_W  = 32;

  localparam logic signed [OUT_W-1:0] OUT_MAX = {1'b0, {(OUT_W-1){1'b1}}};
  localparam logic signed [OUT_W-1:0] OUT_MIN = {1'b1, {(OUT_W-1){1'b0}}};

  localparam int LATENCY = 5;

endpackage

`default_nettype wire

// ----- hdl/quaternion_vector_rotate.sv -----
// Top level: pipelined rotation of a 3-vector by a quaternion, q * (0,v) * conj(q).
`default_nettype none

`include "quaternion_vector_rotate_macros.svh"

// Takes one item in every cycle and never raises busy_o. Five register stages (products
// of q and v, first rounding, products of p and q, second rounding, clip) put each
// result on the ports in the same cycle as done_o goes high for it. The result strobe lasts
// one cycle and cannot be held off, so the results must be taken as they appear.
// A non-unit quaternion scales the result by its squared norm; components that
// overflow 32 bits clip and raise saturated_o.
module quaternion_vector_rotate
  import qvr_pkg::*;
#(
  parameter int QUAT_FRAC_BITS = 16
) (
  input  wire logic                     clk_i,
  input  wire logic                     rst_ni,
  input  wire logic                     start_i,
  output logic                          busy_o,
  input  wire logic signed [QUAT_W-1:0] quat_w_i,
  input  wire logic signed [QUAT_W-1:0] quat_x_i,
  input  wire logic signed [QUAT_W-1:0] quat_y_i,
  input  wire logic signed [QUAT_W-1:0] quat_z_i,
  input  wire logic signed [VEC_W-1:0]  vec_x_i,
  input  wire logic signed [VEC_W-1:0]  vec_y_i,
  input  wire logic signed [VEC_W-1:0]  vec_z_i,
  output logic                          done_o,
  output logic signed [OUT_W-1:0]       rot_x_o,
  output logic signed [OUT_W-1:0]       rot_y_o,
  output logic signed [OUT_W-1:0]       rot_z_o,
  output logic                          saturated_o
);

  localparam int QF  = QUAT_FRAC_BITS;
  localparam int MW1 = QUAT_W + VEC_W;
  localparam int SW1 = MW1 + 2;
  localparam int PW  = SW1 + 1 - QF;
  localparam int MW2 = PW + QUAT_W;
  localparam int SW2 = MW2 + 2;
  localparam int RW  = SW2 + 1 - QF;
  localparam int RWX = (RW > OUT_W) ? RW : OUT_W + 1;

  localparam logic signed [SW1:0] RND1 = {{SW1{1'b0}}, 1'b1} << (QF - 1);
  localparam logic signed [SW2:0] RND2 = {{SW2{1'b0}}, 1'b1} << (QF - 1);

  localparam logic signed [RWX-1:0] R_MAX = {{(RWX-OUT_W+1){1'b0}}, {(OUT_W-1){1'b1}}};
  localparam logic signed [RWX-1:0] R_MIN = {{(RWX-OUT_W+1){1'b1}}, {(OUT_W-1){1'b0}}};

  logic accept;
  logic [LATENCY-1:0] vld_q;

  // quaternion (w, x, y, z) carried to the second product stage
  logic signed [QUAT_W-1:0] q1_q [4];
  logic signed [QUAT_W-1:0] q2_q [4];

  logic signed [MW1-1:0] m1_d [12];
  logic signed [MW1-1:0] m1_q [12];
  logic signed [SW1:0]   s1   [4];
  logic signed [PW-1:0]  p_d  [4];
  logic signed [PW-1:0]  p_q  [4];
  logic signed [MW2-1:0] m2_d [12];
  logic signed [MW2-1:0] m2_q [12];
  logic signed [SW2:0]   s2   [3];
  logic signed [RWX-1:0] r_d  [3];
  logic signed [RWX-1:0] r_q  [3];
  logic signed [OUT_W-1:0] o_d [3];
  logic [2:0] clip;

  assign busy_o = 1'b0;
  assign accept = start_i && !busy_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else begin
      vld_q <= {vld_q[LATENCY-2:0], accept};
    end
  end

  // Stage 1: products q * v
  always_comb begin
    m1_d[0]  = MW1'(quat_x_i) * MW1'(vec_x_i);
    m1_d[1]  = MW1'(quat_y_i) * MW1'(vec_y_i);
    m1_d[2]  = MW1'(quat_z_i) * MW1'(vec_z_i);
    m1_d[3]  = MW1'(quat_w_i) * MW1'(vec_x_i);
    m1_d[4]  = MW1'(quat_y_i) * MW1'(vec_z_i);
    m1_d[5]  = MW1'(quat_z_i) * MW1'(vec_y_i);
    m1_d[6]  = MW1'(quat_w_i) * MW1'(vec_y_i);
    m1_d[7]  = MW1'(quat_x_i) * MW1'(vec_z_i);
    m1_d[8]  = MW1'(quat_z_i) * MW1'(vec_x_i);
    m1_d[9]  = MW1'(quat_w_i) * MW1'(vec_z_i);
    m1_d[10] = MW1'(quat_x_i) * MW1'(vec_y_i);
    m1_d[11] = MW1'(quat_y_i) * MW1'(vec_x_i);
  end

  always_ff @(posedge clk_i) begin
    m1_q    <= m1_d;
    q1_q[0] <= quat_w_i;
    q1_q[1] <= quat_x_i;
    q1_q[2] <= quat_y_i;
    q1_q[3] <= quat_z_i;
  end

  // Stage 2: p = q * (0, v), rounded half up
  always_comb begin
    s1[0] = RND1 - (SW1+1)'(m1_q[0]) - (SW1+1)'(m1_q[1]) - (SW1+1)'(m1_q[2]);
    s1[1] = RND1 + (SW1+1)'(m1_q[3]) + (SW1+1)'(m1_q[4]) - (SW1+1)'(m1_q[5]);
    s1[2] = RND1 + (SW1+1)'(m1_q[6]) - (SW1+1)'(m1_q[7]) + (SW1+1)'(m1_q[8]);
    s1[3] = RND1 + (SW1+1)'(m1_q[9]) + (SW1+1)'(m1_q[10]) - (SW1+1)'(m1_q[11]);
    for (int i = 0; i < 4; i++) begin
      p_d[i] = $signed(s1[i][SW1:QF]);
    end
  end

  always_ff @(posedge clk_i) begin
    p_q  <= p_d;
    q2_q <= q1_q;
  end

  // Stage 3: products p * conj(q); p and q ordered (w, x, y, z)
  always_comb begin
    m2_d[0]  = MW2'(p_q[0]) * MW2'(q2_q[1]);
    m2_d[1]  = MW2'(p_q[1]) * MW2'(q2_q[0]);
    m2_d[2]  = MW2'(p_q[2]) * MW2'(q2_q[3]);
    m2_d[3]  = MW2'(p_q[3]) * MW2'(q2_q[2]);
    m2_d[4]  = MW2'(p_q[0]) * MW2'(q2_q[2]);
    m2_d[5]  = MW2'(p_q[1]) * MW2'(q2_q[3]);
    m2_d[6]  = MW2'(p_q[2]) * MW2'(q2_q[0]);
    m2_d[7]  = MW2'(p_q[3]) * MW2'(q2_q[1]);
    m2_d[8]  = MW2'(p_q[0]) * MW2'(q2_q[3]);
    m2_d[9]  = MW2'(p_q[1]) * MW2'(q2_q[2]);
    m2_d[10] = MW2'(p_q[2]) * MW2'(q2_q[1]);
    m2_d[11] = MW2'(p_q[3]) * MW2'(q2_q[0]);
  end

  always_ff @(posedge clk_i) begin
    m2_q <= m2_d;
  end

  // Stage 4: r, rounded half up
  always_comb begin
    s2[0] = RND2 - (SW2+1)'(m2_q[0]) + (SW2+1)'(m2_q[1])
                 - (SW2+1)'(m2_q[2]) + (SW2+1)'(m2_q[3]);
    s2[1] = RND2 - (SW2+1)'(m2_q[4]) + (SW2+1)'(m2_q[5])
                 + (SW2+1)'(m2_q[6]) - (SW2+1)'(m2_q[7]);
    s2[2] = RND2 - (SW2+1)'(m2_q[8]) - (SW2+1)'(m2_q[9])
                 + (SW2+1)'(m2_q[10]) + (SW2+1)'(m2_q[11]);
    for (int i = 0; i < 3; i++) begin
      r_d[i] = RWX'($signed(s2[i][SW2:QF]));
    end
  end

  always_ff @(posedge clk_i) begin
    r_q <= r_d;
  end

  // Stage 5: clip to 32 bits
  always_comb begin
    for (int i = 0; i < 3; i++) begin
      if (r_q[i] > R_MAX) begin
        o_d[i]  = OUT_MAX;
        clip[i] = 1'b1;
      end else if (r_q[i] < R_MIN) begin
        o_d[i]  = OUT_MIN;
        clip[i] = 1'b1;
      end else begin
        o_d[i]  = r_q[i][OUT_W-1:0];
        clip[i] = 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    rot_x_o     <= o_d[0];
    rot_y_o     <= o_d[1];
    rot_z_o     <= o_d[2];
    saturated_o <= |clip;
  end

  assign done_o = vld_q[LATENCY-1];

  `QVR_ASSERT_LAT(a_done_follows_start, accept, LATENCY, done_o, "transfer without result")
  `QVR_ASSERT_IMP(a_done_has_start, done_o, $past(accept, LATENCY), "result without transfer")
  `QVR_ASSERT_IMP(a_sat_at_limit, done_o && saturated_o,
    rot_x_o == OUT_MAX || rot_x_o == OUT_MIN || rot_y_o == OUT_MAX ||
    rot_y_o == OUT_MIN || rot_z_o == OUT_MAX || rot_z_o == OUT_MIN,
    "saturated with no component at a limit")

endmodule

`default_nettype wire
